/* rtl/ifrf_pkg.sv */
package ifrf_pkg;

   localparam int FRAME_BYTES_DEF = 256;
   localparam int RING_BYTES_DEF  = 512;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 16;
   localparam int FLEN_W = 9;
   localparam int PEND_W = 9;
   localparam int CNT_W  = 32;

   typedef enum logic [1:0] {
      KIND_RX_BYTE,
      KIND_IDLE_LINE,
      KIND_OPEN,
      KIND_READ
   } kind_type;

   typedef enum logic [3:0] {
      STAT_STORED    = 4'd0,
      STAT_OVERRUN   = 4'd1,
      STAT_QUEUED    = 4'd2,
      STAT_DROPPED   = 4'd3,
      STAT_NO_FRAME  = 4'd4,
      STAT_TOO_LONG  = 4'd5,
      STAT_OPENED    = 4'd6,
      STAT_BYTE_OUT  = 4'd7,
      STAT_NOTHING   = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_HDR_HI,
      FSM_COPY,
      FSM_OPEN_LO,
      FSM_OPEN_HI,
      FSM_READ_WAIT,
      FSM_EMIT
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic [BYTE_W-1:0]  rx_byte;
      logic [LEN_W-1:0]   capacity;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [FLEN_W-1:0]  frame_length;
      logic [BYTE_W-1:0]  data_byte;
      logic               last_byte;
      logic [PEND_W-1:0]  frames_pending;
      logic [CNT_W-1:0]   overrun_count;
      logic [CNT_W-1:0]   drop_count;
      logic [CNT_W-1:0]   reset_count;
      logic [CNT_W-1:0]   bytes_received;
      logic [CNT_W-1:0]   frames_received;
   } rsp_type;

endpackage

/* rtl/ifrf_req_if.sv */
interface ifrf_req_if;
   import ifrf_pkg::*;

   logic               valid;
   logic               ready;
   kind_type           kind;
   logic [BYTE_W-1:0]  rx_byte;
   logic [LEN_W-1:0]   capacity;

   modport source (output valid, output kind, output rx_byte, output capacity, input ready);
   modport sink   (input valid, input kind, input rx_byte, input capacity, output ready);
endinterface

/* rtl/ifrf_rsp_if.sv */
interface ifrf_rsp_if;
   import ifrf_pkg::*;

   logic               valid;
   logic               ready;
   status_type         status;
   logic [FLEN_W-1:0]  frame_length;
   logic [BYTE_W-1:0]  data_byte;
   logic               last_byte;
   logic [PEND_W-1:0]  frames_pending;
   logic [CNT_W-1:0]   overrun_count;
   logic [CNT_W-1:0]   drop_count;
   logic [CNT_W-1:0]   reset_count;
   logic [CNT_W-1:0]   bytes_received;
   logic [CNT_W-1:0]   frames_received;

   modport source (output valid, output status, output frame_length, output data_byte,
                   output last_byte, output frames_pending, output overrun_count,
                   output drop_count, output reset_count, output bytes_received,
                   output frames_received, input ready);
   modport sink   (input valid, input status, input frame_length, input data_byte,
                   input last_byte, input frames_pending, input overrun_count,
                   input drop_count, input reset_count, input bytes_received,
                   input frames_received, output ready);
endinterface

/* rtl/idle_framed_rx_fifo.sv */
// Receive FIFO for an idle-line framed serial port.
// req_chan carries one beat per event: a received byte, an idle-line mark that
// closes the frame, an open request with the reader's capacity, or a one-byte
// read. rsp_chan returns exactly one beat per request beat, in order, with the
// status, frame length, data byte, last mark, pending count and the counters.
// States of a request from accept to the response register, by kind:
//   received byte, dropped frame, empty open or empty read: IDLE, EMIT
//   byte read: IDLE, READ_WAIT, EMIT; open: IDLE, OPEN_LO, OPEN_HI, EMIT
//   queued frame: IDLE, HDR_HI, COPY for the N collected bytes, EMIT, with
//   one frame-buffer read and one ring write per cycle through the two RAMs.
// A new request is taken only once the previous one has reached the response
// register.
// Reset empties the frame buffer, the ring and all counters at once; RAM
// contents are left as they are. When the receiver stalls, the response
// register holds its beat and one more request is processed and parked;
// req_chan.ready then stays low until the response register frees.
module idle_framed_rx_fifo #(
   parameter int FRAME_BYTES = ifrf_pkg::FRAME_BYTES_DEF,
   parameter int RING_BYTES  = ifrf_pkg::RING_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   ifrf_req_if.sink          req_chan,
   ifrf_rsp_if.source        rsp_chan
);
   import ifrf_pkg::*;

   req_type req_beat;
   rsp_type core_rsp;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    core_valid;
   logic    core_ready;
   logic    slot_free;

   assign req_beat.kind     = req_chan.kind;
   assign req_beat.rx_byte  = req_chan.rx_byte;
   assign req_beat.capacity = req_chan.capacity;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   ifrf_ctrl #(.FRAME_BYTES(FRAME_BYTES), .RING_BYTES(RING_BYTES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (core_ready),
      .in_req    (req_beat),
      .out_valid (core_valid),
      .out_free  (slot_free),
      .out_rsp   (core_rsp)
   );

   assign req_chan.ready = core_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_valid && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (core_valid && slot_free) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.frame_length    = rsp_ff.frame_length;
   assign rsp_chan.data_byte       = rsp_ff.data_byte;
   assign rsp_chan.last_byte       = rsp_ff.last_byte;
   assign rsp_chan.frames_pending  = rsp_ff.frames_pending;
   assign rsp_chan.overrun_count   = rsp_ff.overrun_count;
   assign rsp_chan.drop_count      = rsp_ff.drop_count;
   assign rsp_chan.reset_count     = rsp_ff.reset_count;
   assign rsp_chan.bytes_received  = rsp_ff.bytes_received;
   assign rsp_chan.frames_received = rsp_ff.frames_received;
endmodule

/* rtl/ifrf_ram.sv */
module ifrf_ram #(
   parameter int WIDTH = ifrf_pkg::BYTE_W,
   parameter int DEPTH = ifrf_pkg::FRAME_BYTES_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/ifrf_ctrl.sv */
module ifrf_ctrl #(
   parameter int FRAME_BYTES = ifrf_pkg::FRAME_BYTES_DEF,
   parameter int RING_BYTES  = ifrf_pkg::RING_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ifrf_pkg::req_type in_req,
   output logic              out_valid,
   input  logic              out_free,
   output ifrf_pkg::rsp_type out_rsp
);
   import ifrf_pkg::*;

   localparam int FILL_W  = $clog2(FRAME_BYTES + 1);
   localparam int FADDR_W = $clog2(FRAME_BYTES);
   localparam int RADDR_W = $clog2(RING_BYTES);
   localparam int USED_W  = $clog2(RING_BYTES + 1);
   localparam int CNTF_W  = $clog2(RING_BYTES / 2 + 1);
   localparam int ROOM_W  = ((USED_W > FILL_W) ? USED_W : FILL_W) + 1;
   localparam int SUM_W   = USED_W + 1;
   localparam int DISC_W  = (LEN_W > USED_W) ? LEN_W : USED_W;

   state_type state_ff, state_in;

   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  copy_ff, copy_in;
   logic [RADDR_W-1:0] head_ff, head_in;
   logic [RADDR_W-1:0] tail_ff, tail_in;
   logic [USED_W-1:0]  used_ff, used_in;
   logic [CNTF_W-1:0]  pend_ff, pend_in;
   logic [LEN_W-1:0]   rrem_ff, rrem_in;
   logic [LEN_W-1:0]   cap_ff, cap_in;
   logic [BYTE_W-1:0]  lo_ff, lo_in;
   status_type         status_ff, status_in;
   logic [FLEN_W-1:0]  flen_ff, flen_in;
   logic [BYTE_W-1:0]  dbyte_ff, dbyte_in;
   logic               last_ff, last_in;
   logic [CNT_W-1:0]   overruns_ff, overruns_in;
   logic [CNT_W-1:0]   drops_ff, drops_in;
   logic [CNT_W-1:0]   clears_ff, clears_in;
   logic [CNT_W-1:0]   bytes_ff, bytes_in;
   logic [CNT_W-1:0]   frames_ff, frames_in;

   logic               f_we;
   logic [FADDR_W-1:0] f_waddr, f_raddr;
   logic [BYTE_W-1:0]  f_wdata, f_rdata;
   logic               r_we;
   logic [RADDR_W-1:0] r_waddr, r_raddr;
   logic [BYTE_W-1:0]  r_wdata, r_rdata;

   logic               accept;
   logic               fill_full;
   logic [ROOM_W-1:0]  room_need;
   logic               no_room;
   logic [USED_W-1:0]  disc_n;
   logic [SUM_W-1:0]   disc_sum;
   logic [RADDR_W-1:0] tail_disc;
   logic [USED_W-1:0]  used_disc;
   logic               open_none;
   logic               read_ok;
   logic [LEN_W-1:0]   hdr_len;
   logic               too_long;
   logic               copy_more;

   function automatic logic [RADDR_W-1:0] ring_next(input logic [RADDR_W-1:0] idx);
      if (idx == RADDR_W'(RING_BYTES - 1)) begin
         return '0;
      end
      return idx + 1'b1;
   endfunction

   ifrf_ram #(.WIDTH(BYTE_W), .DEPTH(FRAME_BYTES)) u_frame_ram (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   ifrf_ram #(.WIDTH(BYTE_W), .DEPTH(RING_BYTES)) u_ring_ram (
      .clock (clock),
      .we    (r_we),
      .waddr (r_waddr),
      .wdata (r_wdata),
      .raddr (r_raddr),
      .rdata (r_rdata)
   );

   assign in_ready  = (state_ff == FSM_IDLE);
   assign accept    = in_valid && in_ready;
   assign out_valid = (state_ff == FSM_EMIT);

   assign fill_full = (fill_ff >= FILL_W'(FRAME_BYTES));
   assign room_need = ROOM_W'(used_ff) + ROOM_W'(fill_ff) + ROOM_W'(2);
   assign no_room   = (room_need > ROOM_W'(RING_BYTES));

   assign disc_n    = (DISC_W'(rrem_ff) < DISC_W'(used_ff)) ? USED_W'(rrem_ff) : used_ff;
   assign disc_sum  = SUM_W'(tail_ff) + SUM_W'(disc_n);
   assign tail_disc = (disc_sum >= SUM_W'(RING_BYTES)) ?
                      RADDR_W'(disc_sum - SUM_W'(RING_BYTES)) : RADDR_W'(disc_sum);
   assign used_disc = used_ff - disc_n;
   assign open_none = (pend_ff == '0) || (used_disc < USED_W'(2));

   assign read_ok   = (rrem_ff != '0) && (used_ff != '0);
   assign hdr_len   = {r_rdata, lo_ff};
   assign too_long  = (hdr_len > cap_ff);
   assign copy_more = (copy_ff < fill_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FSM_IDLE;
         fill_ff     <= '0;
         copy_ff     <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         used_ff     <= '0;
         pend_ff     <= '0;
         rrem_ff     <= '0;
         overruns_ff <= '0;
         drops_ff    <= '0;
         clears_ff   <= '0;
         bytes_ff    <= '0;
         frames_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         copy_ff     <= copy_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         used_ff     <= used_in;
         pend_ff     <= pend_in;
         rrem_ff     <= rrem_in;
         overruns_ff <= overruns_in;
         drops_ff    <= drops_in;
         clears_ff   <= clears_in;
         bytes_ff    <= bytes_in;
         frames_ff   <= frames_in;
      end
      cap_ff    <= cap_in;
      lo_ff     <= lo_in;
      status_ff <= status_in;
      flen_ff   <= flen_in;
      dbyte_ff  <= dbyte_in;
      last_ff   <= last_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               case (in_req.kind)
                  KIND_RX_BYTE:   state_in = FSM_EMIT;
                  KIND_IDLE_LINE: state_in = no_room ? FSM_EMIT : FSM_HDR_HI;
                  KIND_OPEN:      state_in = open_none ? FSM_EMIT : FSM_OPEN_LO;
                  KIND_READ:      state_in = read_ok ? FSM_READ_WAIT : FSM_EMIT;
                  default:        state_in = FSM_EMIT;
               endcase
            end
         end
         FSM_HDR_HI:    state_in = (fill_ff != '0) ? FSM_COPY : FSM_EMIT;
         FSM_COPY:      state_in = copy_more ? FSM_COPY : FSM_EMIT;
         FSM_OPEN_LO:   state_in = FSM_OPEN_HI;
         FSM_OPEN_HI:   state_in = FSM_EMIT;
         FSM_READ_WAIT: state_in = FSM_EMIT;
         FSM_EMIT:      state_in = out_free ? FSM_IDLE : FSM_EMIT;
         default:       state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      fill_in     = fill_ff;
      copy_in     = copy_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      used_in     = used_ff;
      pend_in     = pend_ff;
      rrem_in     = rrem_ff;
      cap_in      = cap_ff;
      lo_in       = lo_ff;
      status_in   = status_ff;
      flen_in     = flen_ff;
      dbyte_in    = dbyte_ff;
      last_in     = last_ff;
      overruns_in = overruns_ff;
      drops_in    = drops_ff;
      clears_in   = clears_ff;
      bytes_in    = bytes_ff;
      frames_in   = frames_ff;

      f_we    = 1'b0;
      f_waddr = fill_ff[FADDR_W-1:0];
      f_wdata = in_req.rx_byte;
      f_raddr = copy_ff[FADDR_W-1:0];
      r_we    = 1'b0;
      r_waddr = head_ff;
      r_wdata = f_rdata;
      r_raddr = tail_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               cap_in   = in_req.capacity;
               flen_in  = '0;
               dbyte_in = '0;
               last_in  = 1'b0;
               copy_in  = '0;
               case (in_req.kind)
                  KIND_RX_BYTE: begin
                     bytes_in = bytes_ff + 1'b1;
                     if (!fill_full) begin
                        f_we      = 1'b1;
                        fill_in   = fill_ff + 1'b1;
                        status_in = STAT_STORED;
                     end else begin
                        overruns_in = overruns_ff + 1'b1;
                        status_in   = STAT_OVERRUN;
                     end
                  end
                  KIND_IDLE_LINE: begin
                     if (no_room) begin
                        drops_in  = drops_ff + 1'b1;
                        status_in = STAT_DROPPED;
                        fill_in   = '0;
                     end else begin
                        r_we      = 1'b1;
                        r_wdata   = fill_ff[BYTE_W-1:0];
                        head_in   = ring_next(head_ff);
                        used_in   = used_ff + 1'b1;
                        pend_in   = pend_ff + 1'b1;
                        frames_in = frames_ff + 1'b1;
                        flen_in   = FLEN_W'(fill_ff);
                        status_in = STAT_QUEUED;
                     end
                  end
                  KIND_OPEN: begin
                     rrem_in = '0;
                     tail_in = tail_disc;
                     used_in = used_disc;
                     if (open_none) begin
                        status_in = STAT_NO_FRAME;
                     end else begin
                        r_raddr = tail_disc;
                        tail_in = ring_next(tail_disc);
                        used_in = used_disc - 1'b1;
                     end
                  end
                  KIND_READ: begin
                     if (read_ok) begin
                        tail_in   = ring_next(tail_ff);
                        used_in   = used_ff - 1'b1;
                        rrem_in   = rrem_ff - 1'b1;
                        last_in   = (rrem_ff == LEN_W'(1));
                        status_in = STAT_BYTE_OUT;
                     end else begin
                        status_in = STAT_NOTHING;
                     end
                  end
                  default: status_in = STAT_NOTHING;
               endcase
            end
         end
         FSM_HDR_HI: begin
            r_we    = 1'b1;
            r_wdata = BYTE_W'(fill_ff >> 8);
            head_in = ring_next(head_ff);
            used_in = used_ff + 1'b1;
            if (fill_ff != '0) begin
               copy_in = copy_ff + 1'b1;
            end else begin
               fill_in = '0;
            end
         end
         FSM_COPY: begin
            r_we    = 1'b1;
            head_in = ring_next(head_ff);
            used_in = used_ff + 1'b1;
            if (copy_more) begin
               copy_in = copy_ff + 1'b1;
            end else begin
               fill_in = '0;
            end
         end
         FSM_OPEN_LO: begin
            lo_in   = r_rdata;
            tail_in = ring_next(tail_ff);
            used_in = used_ff - 1'b1;
         end
         FSM_OPEN_HI: begin
            pend_in = pend_ff - 1'b1;
            if (too_long) begin
               head_in   = '0;
               tail_in   = '0;
               used_in   = '0;
               pend_in   = '0;
               clears_in = clears_ff + 1'b1;
               status_in = STAT_TOO_LONG;
            end else begin
               rrem_in   = hdr_len;
               flen_in   = FLEN_W'(hdr_len);
               status_in = STAT_OPENED;
            end
         end
         FSM_READ_WAIT: begin
            dbyte_in = r_rdata;
         end
         FSM_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_rsp.status          = status_ff;
      out_rsp.frame_length    = flen_ff;
      out_rsp.data_byte       = dbyte_ff;
      out_rsp.last_byte       = last_ff;
      out_rsp.frames_pending  = PEND_W'(pend_ff);
      out_rsp.overrun_count   = overruns_ff;
      out_rsp.drop_count      = drops_ff;
      out_rsp.reset_count     = clears_ff;
      out_rsp.bytes_received  = bytes_ff;
      out_rsp.frames_received = frames_ff;
   end
endmodule

/* test/idle_framed_rx_fifo_tb.sv */
module idle_framed_rx_fifo_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ifrf_pkg::*;

   localparam int ITEMS       = 1900;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 16;

   class frame_ring_board;
      logic [BYTE_W-1:0] frame_buf[FRAME_BYTES_DEF];
      logic [BYTE_W-1:0] ring_buf[RING_BYTES_DEF];
      int fill      = 0;
      int head      = 0;
      int tail      = 0;
      int used      = 0;
      int pending   = 0;
      int remaining = 0;
      logic [CNT_W-1:0] overruns    = '0;
      logic [CNT_W-1:0] drops       = '0;
      logic [CNT_W-1:0] clears      = '0;
      logic [CNT_W-1:0] byte_total  = '0;
      logic [CNT_W-1:0] frame_total = '0;
      rsp_type replies_due[$];
      int fails        = 0;
      int replies_seen = 0;

      function void push(logic [BYTE_W-1:0] v);
         ring_buf[head] = v;
         head = (head + 1) % RING_BYTES_DEF;
         used++;
      endfunction

      function logic [BYTE_W-1:0] pop();
         logic [BYTE_W-1:0] v;
         v = ring_buf[tail];
         tail = (tail + 1) % RING_BYTES_DEF;
         if (used > 0) used--;
         return v;
      endfunction

      function void take_event(kind_type k, logic [BYTE_W-1:0] b, logic [LEN_W-1:0] cap);
         rsp_type r;
         logic [BYTE_W-1:0] lo;
         logic [BYTE_W-1:0] hi;
         int len;
         r = '0;
         r.status = STAT_NOTHING;
         case (k)
            KIND_RX_BYTE: begin
               byte_total++;
               if (fill < FRAME_BYTES_DEF) begin
                  frame_buf[fill] = b;
                  fill++;
                  r.status = STAT_STORED;
               end else begin
                  overruns++;
                  r.status = STAT_OVERRUN;
               end
            end
            KIND_IDLE_LINE: begin
               if (RING_BYTES_DEF - used < fill + 2) begin
                  drops++;
                  r.status = STAT_DROPPED;
               end else begin
                  push(BYTE_W'(fill));
                  push(BYTE_W'(fill >> 8));
                  for (int i = 0; i < fill; i++) push(frame_buf[i]);
                  pending++;
                  frame_total++;
                  r.frame_length = FLEN_W'(fill);
                  r.status = STAT_QUEUED;
               end
               fill = 0;
            end
            KIND_OPEN: begin
               while (remaining > 0 && used > 0) begin
                  void'(pop());
                  remaining--;
               end
               remaining = 0;
               if (pending == 0 || used < 2) begin
                  r.status = STAT_NO_FRAME;
               end else begin
                  lo = pop();
                  hi = pop();
                  len = int'({hi, lo});
                  pending--;
                  if (len > int'(cap)) begin
                     head = 0;
                     tail = 0;
                     used = 0;
                     pending = 0;
                     clears++;
                     r.status = STAT_TOO_LONG;
                  end else begin
                     remaining = len;
                     r.frame_length = FLEN_W'(len);
                     r.status = STAT_OPENED;
                  end
               end
            end
            default: begin
               if (remaining > 0 && used > 0) begin
                  r.data_byte = pop();
                  remaining--;
                  r.last_byte = (remaining == 0);
                  r.status = STAT_BYTE_OUT;
               end
            end
         endcase
         r.frames_pending  = PEND_W'(pending);
         r.overrun_count   = overruns;
         r.drop_count      = drops;
         r.reset_count     = clears;
         r.bytes_received  = byte_total;
         r.frames_received = frame_total;
         replies_due.push_back(r);
      endfunction

      function void same_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
         end
      endfunction

      function void match_reply(rsp_type got);
         rsp_type want;
         replies_seen++;
         if (replies_due.size() == 0) begin
            $error("reply beat with nothing outstanding, status %0d", got.status);
            fails++;
            return;
         end
         want = replies_due.pop_front();
         same_field("status", want.status, got.status);
         same_field("frame_length", want.frame_length, got.frame_length);
         same_field("data_byte", want.data_byte, got.data_byte);
         same_field("last_byte", want.last_byte, got.last_byte);
         same_field("frames_pending", want.frames_pending, got.frames_pending);
         same_field("overrun_count", want.overrun_count, got.overrun_count);
         same_field("drop_count", want.drop_count, got.drop_count);
         same_field("reset_count", want.reset_count, got.reset_count);
         same_field("bytes_received", want.bytes_received, got.bytes_received);
         same_field("frames_received", want.frames_received, got.frames_received);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ifrf_req_if req_chan ();
   ifrf_rsp_if rsp_chan ();

   idle_framed_rx_fifo u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   frame_ring_board board = new;
   int beats_sent = 0;
   int phase      = 0;
   int quiet      = 0;

   always #5 clock = ~clock;

   function automatic int tx_idle_pct();
      return (phase == 0) ? 32 : (phase == 1) ? 66 : 0;
   endfunction

   function automatic int rx_idle_pct();
      return (phase == 0) ? 66 : (phase == 1) ? 32 : 0;
   endfunction

   function automatic logic [LEN_W-1:0] pick_capacity();
      int r;
      r = $urandom_range(99);
      if (r < 85) return LEN_W'($urandom_range(65535, 256));
      if (r < 95) return LEN_W'($urandom_range(8));
      return LEN_W'($urandom_range(65535));
   endfunction

   task automatic send_beat(input kind_type k, input logic [BYTE_W-1:0] b,
                            input logic [LEN_W-1:0] c);
      while ($urandom_range(99) < tx_idle_pct()) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.kind     <= k;
      req_chan.rx_byte  <= b;
      req_chan.capacity <= c;
      do @(posedge clock); while (!req_chan.ready);
      board.take_event(k, b, c);
      beats_sent++;
      phase = (beats_sent < ITEMS / 3) ? 0 : (beats_sent < 2 * ITEMS / 3) ? 1 : 2;
      @(negedge clock);
   endtask

   task automatic send_frame(input int n);
      repeat (n) send_beat(KIND_RX_BYTE, BYTE_W'($urandom_range(255)),
                           LEN_W'($urandom_range(65535)));
      send_beat(KIND_IDLE_LINE, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(65535)));
   endtask

   task automatic open_and_read();
      int n;
      send_beat(KIND_OPEN, BYTE_W'($urandom_range(255)), pick_capacity());
      n = board.remaining;
      case ($urandom_range(9))
         0: n = n + 1;
         1: n = $urandom_range(n);
         default: ;
      endcase
      repeat (n) send_beat(KIND_READ, BYTE_W'($urandom_range(255)),
                           LEN_W'($urandom_range(65535)));
   endtask

   initial begin
      int stall_left;
      int hold_phase;
      stall_left = 0;
      hold_phase = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase != hold_phase) begin
            hold_phase = phase;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_idle_pct());
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status          = rsp_chan.status;
         got.frame_length    = rsp_chan.frame_length;
         got.data_byte       = rsp_chan.data_byte;
         got.last_byte       = rsp_chan.last_byte;
         got.frames_pending  = rsp_chan.frames_pending;
         got.overrun_count   = rsp_chan.overrun_count;
         got.drop_count      = rsp_chan.drop_count;
         got.reset_count     = rsp_chan.reset_count;
         got.bytes_received  = rsp_chan.bytes_received;
         got.frames_received = rsp_chan.frames_received;
         board.match_reply(got);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet <= 0;
      end else if (quiet + 1 >= STALL_LIMIT) begin
         $display("idle_framed_rx_fifo: mismatch");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int seq;
      int pick;
      seq = 0;
      reset = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.kind     = KIND_RX_BYTE;
      req_chan.rx_byte  = '0;
      req_chan.capacity = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      send_beat(KIND_OPEN, 8'h00, 16'hFFFF);
      send_beat(KIND_READ, 8'hFF, 16'h0000);
      send_beat(KIND_IDLE_LINE, 8'h00, 16'h0000);
      send_beat(KIND_OPEN, 8'h00, 16'h0000);
      send_beat(KIND_READ, 8'h00, 16'h0000);
      send_beat(KIND_RX_BYTE, 8'h00, 16'h0000);
      send_beat(KIND_RX_BYTE, 8'hFF, 16'hFFFF);
      send_beat(KIND_RX_BYTE, 8'h5A, 16'h0000);
      send_beat(KIND_IDLE_LINE, 8'h00, 16'h0000);
      send_beat(KIND_OPEN, 8'h00, 16'h0003);
      repeat (4) send_beat(KIND_READ, 8'h00, 16'h0000);
      send_beat(KIND_RX_BYTE, 8'hA5, 16'h0000);
      send_beat(KIND_RX_BYTE, 8'h3C, 16'h0000);
      send_beat(KIND_IDLE_LINE, 8'h00, 16'h0000);
      send_beat(KIND_RX_BYTE, 8'h01, 16'h0000);
      send_beat(KIND_IDLE_LINE, 8'h00, 16'h0000);
      send_beat(KIND_OPEN, 8'h00, 16'hFFFF);
      send_beat(KIND_READ, 8'h00, 16'h0000);
      send_beat(KIND_OPEN, 8'h00, 16'hFFFF);
      send_beat(KIND_RX_BYTE, 8'h07, 16'h0000);
      send_beat(KIND_IDLE_LINE, 8'h00, 16'h0000);
      send_beat(KIND_OPEN, 8'h00, 16'h0000);
      send_beat(KIND_OPEN, 8'h00, 16'hFFFF);

      while (beats_sent < ITEMS) begin
         seq++;
         pick = $urandom_range(99);
         if (seq % 20 == 5 || (pick >= 72 && pick < 76)) begin
            send_frame($urandom_range(264, 248));
            if ($urandom_range(1)) open_and_read();
         end else if (seq % 20 == 12 || (pick >= 50 && pick < 54)) begin
            repeat ($urandom_range(9, 5)) send_frame($urandom_range(90, 40));
         end else if (pick < 50) begin
            send_frame(($urandom_range(99) < 75) ? $urandom_range(8) : $urandom_range(40, 9));
            open_and_read();
         end else if (pick < 72) begin
            repeat ($urandom_range(4, 1)) open_and_read();
         end else begin
            repeat ($urandom_range(6, 1))
               send_beat(kind_type'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                         LEN_W'($urandom_range(65535)));
         end
      end
      req_chan.valid <= 1'b0;

      while (board.replies_due.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d request beats and %0d reply beats in three idling phases",
               beats_sent, board.replies_seen);
      $display("counters reached: %0d overruns, %0d drops, %0d ring clears, %0d frames",
               board.overruns, board.drops, board.clears, board.frame_total);
      if (board.fails == 0) begin
         $display("idle_framed_rx_fifo: match");
      end else begin
         $display("idle_framed_rx_fifo: mismatch");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/ifrf_pkg.sv
rtl/ifrf_req_if.sv
rtl/ifrf_rsp_if.sv
rtl/ifrf_ram.sv
rtl/ifrf_ctrl.sv
rtl/idle_framed_rx_fifo.sv
test/idle_framed_rx_fifo_tb.sv
